>>> hdl/u16u8_pkg.sv
// types, constants and the byte encoder for the utf-16 to utf-8 transcoder
// no dependencies; imported by hdl/utf16_to_utf8_transcoder.sv
package u16u8_pkg;

   // encoding_mode register codes
   localparam logic [1:0] MODE_DETECT = 2'd0;
   localparam logic [1:0] MODE_LITTLE = 2'd1;
   localparam logic [1:0] MODE_BIG    = 2'd2;

   // item kinds
   localparam logic KIND_UNIT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
   localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
   localparam logic [15:0] SURR_MASK   = 16'hFC00;
   localparam logic [15:0] SURR_HIGH   = 16'hD800;
   localparam logic [15:0] SURR_LOW    = 16'hDC00;
   localparam logic [20:0] CP_SUPP     = 21'h10000;

   localparam int unsigned RUN_DEPTH = 4;

   typedef struct packed {
      logic        kind;
      logic [15:0] code_unit;
   } req_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       last_byte;
      logic       bad_sequence;
   } rsp_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;   // index 0 goes out first
      logic [2:0]      count;
   } utf8_enc_type;

   function automatic utf8_enc_type utf8_encode(input logic [20:0] cp);
      utf8_enc_type e;
      e.bytes = '0;
      if (cp <= 21'h7F) begin
         e.bytes[0] = cp[7:0];
         e.count    = 3'd1;
      end else if (cp <= 21'h7FF) begin
         e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
         e.count    = 3'd2;
      end else if (cp <= 21'hFFFF) begin
         e.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
         e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
         e.count    = 3'd3;
      end else begin
         e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
         e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
         e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
         e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
         e.count    = 3'd4;
      end
      return e;
   endfunction

endpackage

>>> hdl/utf16_to_utf8_transcoder.sv
// utf-16 to utf-8 transcoder, top level
// depends on hdl/u16u8_pkg.sv (payload types, mode codes, byte encoder)
//
// usage:
//  - req channel (valid/ready) carries one item: a 16-bit code unit, or an
//    end-of-stream mark (kind = 1)
//  - rsp channel (valid/ready) carries one utf-8 byte per item, with
//    last_byte on the final byte of an input's run and bad_sequence on the
//    error byte that an unpaired surrogate or a broken pair produces
//  - csr_wr_en / csr_wr_data write encoding_mode; write it only while idle
//  - latency: the first byte of a run is shown in the cycle after its item
//    is accepted
//  - an input that yields n bytes (one to four) holds the result buffer until
//    all n are taken, one per handshake; an input that yields none leaves it free.
//    the byte-wide result port sets this limit
//  - the next item is taken in the same cycle the last byte of the current
//    run is taken, so runs follow each other with no gap
//  - reset: buffer empty, mode detect, stream start, no surrogate held
//  - when the receiver stalls, the current byte holds and req_ready stays
//    low until the final byte of the run is taken
module utf16_to_utf8_transcoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  u16u8_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output u16u8_pkg::rsp_type  rsp_data,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data
);
   import u16u8_pkg::*;

   // configuration and stream state
   logic [1:0] mode_ff, mode_in;
   logic       at_start_ff, at_start_in;
   logic       swap_ff, swap_in;
   logic       pending_ff, pending_in;
   logic [9:0] high_bits_ff, high_bits_in;

   // result buffer: one run of up to four bytes, read out by index
   rsp_type    run_ff [RUN_DEPTH];
   rsp_type    run_in [RUN_DEPTH];
   logic       run_valid_ff, run_valid_in;
   logic [1:0] run_idx_ff, run_idx_in;

   // decode of the incoming item
   logic            take;
   logic            rsp_done;
   logic            swap_sel;
   logic            is_mark;
   logic [15:0]     unit_sw;
   logic            is_high;
   logic            is_low;
   logic [20:0]     cp;
   utf8_enc_type    enc;
   logic            err_lead;   // error byte heads the run
   logic            emit;       // code point bytes follow
   logic [2:0]      count;
   logic [3:0][7:0] shifted;

   assign rsp_valid = run_valid_ff;
   assign rsp_data  = run_ff[run_idx_ff];
   assign rsp_done  = rsp_valid && rsp_ready;
   // free when empty or when the run's final byte leaves this cycle
   assign req_ready = !run_valid_ff || (rsp_ready && run_ff[run_idx_ff].last_byte);
   assign take      = req_valid && req_ready;

   // byte order: detect mode follows the mark, else bit 1 of the mode
   assign swap_sel = (mode_ff == MODE_DETECT) ? swap_ff : mode_ff[1];
   assign is_mark  = (mode_ff == MODE_DETECT) && at_start_ff &&
                     ((req_data.code_unit == BOM_NATIVE) ||
                      (req_data.code_unit == BOM_SWAPPED));
   assign unit_sw  = swap_sel ? {req_data.code_unit[7:0], req_data.code_unit[15:8]}
                              : req_data.code_unit;
   assign is_high  = (unit_sw & SURR_MASK) == SURR_HIGH;
   assign is_low   = (unit_sw & SURR_MASK) == SURR_LOW;

   // a low surrogate after a held high one forms a supplementary code point
   assign cp  = (is_low && pending_ff) ? ({1'b0, high_bits_ff, unit_sw[9:0]} + CP_SUPP)
                                       : {5'd0, unit_sw};
   assign enc = utf8_encode(cp);

   always_comb begin
      err_lead = 1'b0;
      emit     = 1'b0;
      if (req_data.kind == KIND_END) begin
         err_lead = pending_ff;
      end else if (!is_mark) begin
         if (is_high) begin
            err_lead = pending_ff;
         end else if (is_low) begin
            err_lead = !pending_ff;
            emit     = pending_ff;
         end else begin
            err_lead = pending_ff;
            emit     = 1'b1;
         end
      end
   end

   assign count   = {2'b00, err_lead} + (emit ? enc.count : 3'd0);
   // an error byte pushes the code point bytes one place along
   assign shifted = err_lead ? {enc.bytes[2:0], 8'h00} : enc.bytes;

   always_comb begin
      mode_in      = mode_ff;
      at_start_in  = at_start_ff;
      swap_in      = swap_ff;
      pending_in   = pending_ff;
      high_bits_in = high_bits_ff;
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      run_idx_in   = run_idx_ff;

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end

      // drain the buffer one byte per handshake
      if (rsp_done) begin
         if (run_ff[run_idx_ff].last_byte) begin
            run_valid_in = 1'b0;
         end else begin
            run_idx_in = run_idx_ff + 2'd1;
         end
      end

      if (take) begin
         if (req_data.kind == KIND_END) begin
            // end of stream: back to the start-of-stream state
            at_start_in  = 1'b1;
            swap_in      = 1'b0;
            pending_in   = 1'b0;
            high_bits_in = '0;
         end else begin
            at_start_in = 1'b0;
            if (is_mark) begin
               swap_in = (req_data.code_unit == BOM_SWAPPED);
            end else if (is_high) begin
               pending_in   = 1'b1;
               high_bits_in = unit_sw[9:0];
            end else begin
               pending_in   = 1'b0;
               high_bits_in = '0;
            end
         end

         if (count != 3'd0) begin
            for (int k = 0; k < RUN_DEPTH; k++) begin
               run_in[k].utf8_byte    = shifted[k];
               run_in[k].bad_sequence = (k == 0) && err_lead;
               run_in[k].last_byte    = (3'(k) == (count - 3'd1));
            end
            run_valid_in = 1'b1;
            run_idx_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DETECT;
         at_start_ff  <= 1'b1;
         swap_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         high_bits_ff <= '0;
         run_valid_ff <= 1'b0;
         run_idx_ff   <= '0;
      end else begin
         mode_ff      <= mode_in;
         at_start_ff  <= at_start_in;
         swap_ff      <= swap_in;
         pending_ff   <= pending_in;
         high_bits_ff <= high_bits_in;
         run_valid_ff <= run_valid_in;
         run_idx_ff   <= run_idx_in;
      end
   end

   // run bytes are payload, no reset needed
   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   // a new item only lands when the buffer is empty or its last byte leaves
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      take |-> (!run_valid_ff || (rsp_ready && run_ff[run_idx_ff].last_byte)))
      else $error("item taken over an undelivered run");

   // error bytes carry a zero byte value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_sequence) |-> (rsp_data.utf8_byte == 8'h00))
      else $error("error result with non-zero byte");

   // an error byte only ever heads a run
   a_err_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_sequence) |-> (run_idx_ff == 2'd0))
      else $error("error result inside a run");

   // end of stream leaves the start-of-stream state behind it
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (take && (req_data.kind == KIND_END)) |=> (at_start_ff && !pending_ff && !swap_ff))
      else $error("stream state not cleared at end of stream");

   // the read index never runs past the final slot without a last mark
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (run_idx_ff == 2'd3)) |-> rsp_data.last_byte)
      else $error("run overran the buffer");

endmodule
